FILE: design/mpr_pkg.sv
package mpr_pkg;

  localparam int PIX_W = 8;
  localparam int CFG_W = 12;
  localparam int SUM_W = 10;

  localparam logic [CFG_W-1:0] CFG_RESET = 12'd512;
  localparam logic [PIX_W-1:0] MSB_MASK  = 8'h80;

  // sum / 3 for sums up to 765: (sum * 683) >> 11 is exact over that range
  function automatic logic [PIX_W-1:0] div3(input logic [SUM_W-1:0] sum);
    logic [20:0] prod;
    prod = 21'(sum) * 21'd683;
    return prod[18:11];
  endfunction

  function automatic logic [PIX_W-1:0] abs_diff(input logic [PIX_W-1:0] a,
                                                input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

FILE: design/mpr_in_if.sv
interface mpr_in_if;

  logic                       valid;
  logic                       ready;
  logic [mpr_pkg::PIX_W-1:0]  pixel_in;
  logic                       frame_start;

  modport source (output valid, output pixel_in, output frame_start, input ready);
  modport sink   (input valid, input pixel_in, input frame_start, output ready);

endinterface

FILE: design/mpr_out_if.sv
interface mpr_out_if;

  logic                       valid;
  logic                       ready;
  logic [mpr_pkg::PIX_W-1:0]  pixel_out;
  logic                       msb_flipped;

  modport source (output valid, output pixel_out, output msb_flipped, input ready);
  modport sink   (input valid, input pixel_out, input msb_flipped, output ready);

endinterface

FILE: design/msb_prediction_restore_unit.sv
// MSB prediction restore unit.
// Input channel in_i carries greyscale pixels in raster order; frame_start
// marks the first pixel of an image. Output channel out_o carries one
// restored pixel per input word, with msb_flipped set when the MSB was
// inverted. Pixels of the first row and first column pass unchanged.
// Row length comes from cfg_wdata_i, loaded when cfg_we_i is high; write it
// only while no word is in flight. Zero acts as one, values above
// MAX_WIDTH act as MAX_WIDTH.
// Throughput: one word per cycle while out_o does not stall. A word accepted
// into the working stage moves on to the output register that drives out_o. The line store is a
// MAX_WIDTH x 8 RAM with one write and one registered read per cycle; the
// word being finished is forwarded to a read of the same column.
// Reset puts the row length to 512, starts at column 0 of a first row, and
// clears the neighbor registers; the line store is not cleared.
// When out_o stalls the finished word waits in the output register; one more
// word is taken into the working stage, then in_i.ready drops until the
// output drains.
module msb_prediction_restore_unit #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [mpr_pkg::CFG_W-1:0]    cfg_wdata_i,
  mpr_in_if.sink                       in_i,
  mpr_out_if.source                    out_o
);
  import mpr_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;

  logic [CFG_W-1:0] cfg_q;
  logic [WW-1:0]    eff_w;

  logic [CW-1:0]    col_q;
  logic             first_q;

  logic             in_acc;
  logic [CW-1:0]    acc_col;
  logic             acc_first;
  logic [WW-1:0]    col_next;
  logic             wrap;

  logic             s1_valid_q;
  logic [PIX_W-1:0] s1_pix_q;
  logic [CW-1:0]    s1_col_q;
  logic             s1_pred_q;
  logic             s1_adv;

  logic [PIX_W-1:0] row_mem [MAX_WIDTH];
  logic [PIX_W-1:0] rd_q;
  logic             byp_q;
  logic [PIX_W-1:0] byp_data_q;

  logic [PIX_W-1:0] left_q;
  logic [PIX_W-1:0] ul_q;

  logic [PIX_W-1:0] upper;
  logic [SUM_W-1:0] sum;
  logic [PIX_W-1:0] pred;
  logic [PIX_W-1:0] alt;
  logic             flip;
  logic [PIX_W-1:0] res;

  logic             out_valid_q;
  logic [PIX_W-1:0] out_pix_q;
  logic             out_flip_q;

  // row length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CFG_RESET;
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    eff_w = WW'(cfg_q);
    if (cfg_q == '0) begin
      eff_w = WW'(1);
    end else if (WW'(cfg_q) > WW'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end
  end

  // handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc     = in_i.valid && in_i.ready;

  // position tracking at accept
  assign acc_col   = in_i.frame_start ? '0 : col_q;
  assign acc_first = in_i.frame_start || first_q;
  assign col_next  = WW'(acc_col) + WW'(1);
  assign wrap      = col_next >= eff_w;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      first_q <= 1'b1;
    end else if (in_acc) begin
      col_q   <= wrap ? '0 : col_next[CW-1:0];
      first_q <= wrap ? 1'b0 : acc_first;
    end
  end

  // working stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      byp_q      <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
        byp_q      <= s1_adv && (s1_col_q == acc_col);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= in_i.pixel_in;
      s1_col_q   <= acc_col;
      s1_pred_q  <= !acc_first && (acc_col != '0);
      byp_data_q <= res;
    end
  end

  // line store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      row_mem[s1_col_q] <= res;
    end
    if (in_acc) begin
      rd_q <= row_mem[acc_col];
    end
  end

  // restore datapath
  always_comb begin
    upper = byp_q ? byp_data_q : rd_q;
    sum   = SUM_W'(left_q) + SUM_W'(ul_q) + SUM_W'(upper);
    pred  = div3(sum);
    alt   = s1_pix_q ^ MSB_MASK;
    flip  = s1_pred_q && (abs_diff(pred, s1_pix_q) > abs_diff(pred, alt));
    res   = flip ? alt : s1_pix_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      ul_q   <= '0;
    end else if (s1_adv) begin
      left_q <= res;
      ul_q   <= upper;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_pix_q  <= res;
      out_flip_q <= flip;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pixel_out   = out_pix_q;
  assign out_o.msb_flipped = out_flip_q;

  // first-row and first-column words are never altered
  a_no_flip_unpredicted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_pred_q) |-> !flip)
    else $error("flip on a pixel without prediction");

  // a frame start lands at column 0 without prediction
  a_frame_start_col0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.frame_start) |=> (s1_valid_q && s1_col_q == '0 && !s1_pred_q))
    else $error("frame start not at column 0");

  // a word is only taken when the working stage can hand off
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && s1_valid_q) |-> s1_adv)
    else $error("working stage overwritten");

  // a flipped result differs from the received word only in its MSB
  a_flip_msb_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv |=> (out_valid_q && ((out_pix_q ^ $past(s1_pix_q)) ==
                                (out_flip_q ? MSB_MASK : '0))))
    else $error("restored pixel inconsistent with flip flag");

endmodule
